@@ rtl/bvfg_pkg.sv @@
// Package for the battery voltage fuel gauge: widths, register indexes,
// controller states and the discharge-curve tables.
// No dependencies.
package bvfg_pkg;

   localparam int TABLE_SIZE   = 43;
   localparam int ADC_BITS     = 12;
   localparam int ROM_SLOTS    = 64;
   localparam int TAB_LEN      = (TABLE_SIZE < 2) ? 2 :
                                 ((TABLE_SIZE > ROM_SLOTS) ? ROM_SLOTS : TABLE_SIZE);
   localparam int IDX_W        = 6;
   localparam int MV_W         = 14;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam logic [MV_W-1:0] MV_MAX = 14'h3FFF;

   localparam logic [CSR_INDEX_W-1:0] REG_VOLT_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_PER_US = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EMPTY_SET   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_EMPTY_CLEAR = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_WEIGHT, ST_BLEND, ST_FLAG, ST_SEARCH,
      ST_DIVIDE, ST_FINISH, ST_OUTPUT
   } state_type;

   // Controller commands to the datapath
   typedef struct packed {
      logic load;
      logic scale;
      logic weight;
      logic blend;
      logic flag;
      logic search_init;
      logic search_step;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   // Datapath status to the controller
   typedef struct packed {
      logic search_done;
      logic need_div;
      logic div_done;
   } status_type;

   function automatic logic [MV_W-1:0] volt_rom(input logic [IDX_W-1:0] idx);
      logic [MV_W-1:0] v;
      case (idx)
         6'd0: v = 14'd2805;  6'd1: v = 14'd2900;  6'd2: v = 14'd2984;  6'd3: v = 14'd3075;
         6'd4: v = 14'd3150;  6'd5: v = 14'd3192;  6'd6: v = 14'd3241;  6'd7: v = 14'd3274;
         6'd8: v = 14'd3301;  6'd9: v = 14'd3327;  6'd10: v = 14'd3367; 6'd11: v = 14'd3406;
         6'd12: v = 14'd3430; 6'd13: v = 14'd3453; 6'd14: v = 14'd3478; 6'd15: v = 14'd3495;
         6'd16: v = 14'd3511; 6'd17: v = 14'd3530; 6'd18: v = 14'd3541; 6'd19: v = 14'd3558;
         6'd20: v = 14'd3571; 6'd21: v = 14'd3583; 6'd22: v = 14'd3599; 6'd23: v = 14'd3616;
         6'd24: v = 14'd3630; 6'd25: v = 14'd3653; 6'd26: v = 14'd3674; 6'd27: v = 14'd3697;
         6'd28: v = 14'd3725; 6'd29: v = 14'd3753; 6'd30: v = 14'd3774; 6'd31: v = 14'd3799;
         6'd32: v = 14'd3823; 6'd33: v = 14'd3860; 6'd34: v = 14'd3888; 6'd35: v = 14'd3909;
         6'd36: v = 14'd3939; 6'd37: v = 14'd3967; 6'd38: v = 14'd4016; 6'd39: v = 14'd4053;
         6'd40: v = 14'd4081; 6'd41: v = 14'd4107;
         default: v = 14'd4156;
      endcase
      return v;
   endfunction

   function automatic logic [MV_W-1:0] cap_rom(input logic [IDX_W-1:0] idx);
      logic [MV_W-1:0] c;
      case (idx)
         6'd0: c = 14'd0;     6'd1: c = 14'd10;    6'd2: c = 14'd64;    6'd3: c = 14'd140;
         6'd4: c = 14'd229;   6'd5: c = 14'd297;   6'd6: c = 14'd434;   6'd7: c = 14'd659;
         6'd8: c = 14'd974;   6'd9: c = 14'd1206;  6'd10: c = 14'd1466; 6'd11: c = 14'd1733;
         6'd12: c = 14'd1938; 6'd13: c = 14'd2184; 6'd14: c = 14'd2478; 6'd15: c = 14'd2690;
         6'd16: c = 14'd2916; 6'd17: c = 14'd3224; 6'd18: c = 14'd3429; 6'd19: c = 14'd3709;
         6'd20: c = 14'd3983; 6'd21: c = 14'd4188; 6'd22: c = 14'd4434; 6'd23: c = 14'd4728;
         6'd24: c = 14'd4960; 6'd25: c = 14'd5234; 6'd26: c = 14'd5487; 6'd27: c = 14'd5719;
         6'd28: c = 14'd6000; 6'd29: c = 14'd6232; 6'd30: c = 14'd6472; 6'd31: c = 14'd6725;
         6'd32: c = 14'd6998; 6'd33: c = 14'd7422; 6'd34: c = 14'd7737; 6'd35: c = 14'd7969;
         6'd36: c = 14'd8249; 6'd37: c = 14'd8502; 6'd38: c = 14'd8879; 6'd39: c = 14'd9248;
         6'd40: c = 14'd9528; 6'd41: c = 14'd9767;
         default: c = 14'd10000;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/battery_voltage_fuel_gauge_unit.sv @@
// Battery voltage fuel gauge top level: configuration registers, controller
// and datapath. Depends on bvfg_pkg, bvfg_ctrl and bvfg_datapath.
// The state sequence runs scale, weight, blend, flag, search, an optional
// interpolation divide at one quotient bit a cycle, finish and output.
// One transaction at a time: a new sample is accepted only after the result
// is taken, so a result stall holds off the next one.
// Reset (synchronous, active high) restores register defaults and clears the
// filtered voltage, the empty flag and the primed flag.
module battery_voltage_fuel_gauge_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_adc_sample,
   input  logic [23:0] req_elapsed_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_voltage_mv,
   output logic [13:0] rsp_capacity_centi_pct,
   output logic        rsp_empty_flag,
   input  logic        csr_write_enable,
   input  logic [bvfg_pkg::CSR_INDEX_W:0]    csr_index,
   input  logic [bvfg_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bvfg_pkg::*;

   logic [23:0] volt_scale_ff;
   logic [31:0] rate_ff;
   logic [13:0] eset_ff, eclear_ff;
   cmd_type     cmd;
   status_type  status;

   // Configuration writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         volt_scale_ff <= 24'd422814;
         rate_ff       <= 32'd69503;
         eset_ff       <= 14'd2800;
         eclear_ff     <= 14'd3000;
      end else if (csr_write_enable && !csr_index[CSR_INDEX_W]) begin
         unique case (csr_index[CSR_INDEX_W-1:0])
            REG_VOLT_SCALE:  volt_scale_ff <= csr_write_data[23:0];
            REG_RATE_PER_US: rate_ff       <= csr_write_data;
            REG_EMPTY_SET:   eset_ff       <= csr_write_data[13:0];
            REG_EMPTY_CLEAR: eclear_ff     <= csr_write_data[13:0];
            default:         ;
         endcase
      end
   end

   bvfg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   bvfg_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_adc_sample, .req_elapsed_us,
      .volt_scale(volt_scale_ff), .rate_per_us(rate_ff),
      .empty_set_mv(eset_ff), .empty_clear_mv(eclear_ff),
      .rsp_voltage_mv, .rsp_capacity_centi_pct, .rsp_empty_flag
   );
endmodule

@@ rtl/bvfg_ctrl.sv @@
// Controller state machine for the fuel gauge: sequences scaling, averaging,
// table search and the interpolation divide. Depends on bvfg_pkg.
module bvfg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bvfg_pkg::status_type  status,
   output bvfg_pkg::cmd_type     cmd
);
   import bvfg_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_BLEND;
         ST_BLEND:  state_in = ST_FLAG;
         ST_FLAG:   state_in = ST_SEARCH;
         ST_SEARCH: if (status.search_done) state_in = status.need_div ? ST_DIVIDE : ST_FINISH;
         ST_DIVIDE: if (status.div_done) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd             = '0;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      unique case (state_ff)
         ST_IDLE:   begin req_ready = 1'b1; cmd.load = req_valid; end
         ST_SCALE:  cmd.scale = 1'b1;
         ST_WEIGHT: cmd.weight = 1'b1;
         ST_BLEND:  cmd.blend = 1'b1;
         ST_FLAG:   begin cmd.flag = 1'b1; cmd.search_init = 1'b1; end
         ST_SEARCH: begin
            cmd.search_step = !status.search_done;
            cmd.div_init    = status.search_done;
         end
         ST_DIVIDE: cmd.div_step = !status.div_done;
         ST_FINISH: cmd.finish = 1'b1;
         ST_OUTPUT: rsp_valid = 1'b1;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready and result valid together");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SCALE) else $error("accept did not start");
endmodule

@@ rtl/bvfg_datapath.sv @@
// Datapath for the fuel gauge: scaling, exponential average, hysteresis,
// binary search and a restoring divider. Depends on bvfg_pkg.
module bvfg_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bvfg_pkg::cmd_type            cmd,
   output bvfg_pkg::status_type         status,
   input  logic [11:0]                  req_adc_sample,
   input  logic [23:0]                  req_elapsed_us,
   input  logic [23:0]                  volt_scale,
   input  logic [31:0]                  rate_per_us,
   input  logic [13:0]                  empty_set_mv,
   input  logic [13:0]                  empty_clear_mv,
   output logic [13:0]                  rsp_voltage_mv,
   output logic [13:0]                  rsp_capacity_centi_pct,
   output logic                         rsp_empty_flag
);
   import bvfg_pkg::*;

   logic [ADC_BITS-1:0] adc_ff;
   logic [23:0]         elapsed_ff;
   logic [MV_W-1:0]     sample_ff, sample_in;
   logic [16:0]         weight_ff;
   logic [MV_W-1:0]     filt_ff;
   logic                primed_ff, empty_ff;
   logic [IDX_W-1:0]    first_ff, last_ff;
   logic                sdone_ff, ndiv_ff;
   logic [MV_W-1:0]     cap_ff;
   logic [27:0]         quo_ff;
   logic [13:0]         rem_ff;
   logic [13:0]         den_ff;
   logic [4:0]          dcnt_ff;

   logic [35:0] scaled;
   logic [55:0] wprod;
   logic [32:0] blend_acc;
   logic [MV_W-1:0] blend_mv;
   logic [IDX_W-1:0] mid;
   logic [MV_W-1:0] vmid, vfirst, vlast, cfirst, clast;
   logic [14:0] rem_sh;

   assign scaled  = ({24'd0, adc_ff} * {12'd0, volt_scale}) + 36'd32768;
   assign sample_in = (scaled[35:16] > {6'd0, MV_MAX}) ? MV_MAX : scaled[29:16];
   assign wprod   = {24'd0, rate_per_us} * {32'd0, elapsed_ff};
   assign blend_acc = ({16'd0, 17'h10000 - weight_ff} * {19'd0, filt_ff})
                    + ({16'd0, weight_ff} * {19'd0, sample_ff}) + 33'd32768;
   assign blend_mv = (blend_acc[32:16] > {3'd0, MV_MAX}) ? MV_MAX : blend_acc[29:16];
   assign mid    = IDX_W'(({1'b0, first_ff} + {1'b0, last_ff}) >> 1);
   assign vmid   = volt_rom(mid);
   assign vfirst = volt_rom(first_ff);
   assign vlast  = volt_rom(last_ff);
   assign cfirst = cap_rom(first_ff);
   assign clast  = cap_rom(last_ff);
   assign rem_sh = {rem_ff, quo_ff[27]};

   // Capture the transaction, the scaled sample and the blend weight
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         adc_ff     <= req_adc_sample[ADC_BITS-1:0];
         elapsed_ff <= req_elapsed_us;
      end
      if (cmd.scale)  sample_ff <= sample_in;
      if (cmd.weight) weight_ff <= (wprod[55:40] != 16'd0) ? 17'h10000 : wprod[40:24];
   end

   // Average and hysteresis state
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff   <= '0;
         primed_ff <= 1'b0;
         empty_ff  <= 1'b0;
      end else begin
         if (cmd.blend) begin
            filt_ff   <= (!primed_ff || weight_ff[16]) ? sample_ff : blend_mv;
            primed_ff <= 1'b1;
         end
         if (cmd.flag) begin
            if (empty_ff && filt_ff > empty_clear_mv) empty_ff <= 1'b0;
            else if (filt_ff < empty_set_mv)          empty_ff <= 1'b1;
         end
      end
   end

   // Binary search, one probe a cycle, then restoring divide one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         first_ff <= '0;
         last_ff  <= IDX_W'(TAB_LEN - 1);
         sdone_ff <= 1'b0;
         ndiv_ff  <= 1'b0;
         if (filt_ff < volt_rom('0)) begin
            cap_ff <= cap_rom('0); sdone_ff <= 1'b1;
         end else if (filt_ff > volt_rom(IDX_W'(TAB_LEN - 1))) begin
            cap_ff <= cap_rom(IDX_W'(TAB_LEN - 1)); sdone_ff <= 1'b1;
         end
      end else if (cmd.search_step) begin
         if ({1'b0, last_ff} - {1'b0, first_ff} > 7'd1) begin
            if (filt_ff > vmid)      first_ff <= mid;
            else if (filt_ff < vmid) last_ff  <= mid;
            else begin cap_ff <= cap_rom(mid); sdone_ff <= 1'b1; end
         end else begin
            sdone_ff <= 1'b1;
            if (vlast <= vfirst || clast < cfirst || filt_ff < vfirst) cap_ff <= cfirst;
            else begin cap_ff <= cfirst; ndiv_ff <= 1'b1; end
         end
      end
      if (cmd.div_init) begin
         quo_ff  <= 28'(({14'd0, clast - cfirst}) * ({14'd0, filt_ff - vfirst}));
         rem_ff  <= '0;
         den_ff  <= vlast - vfirst;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[26:0], rem_sh >= {1'b0, den_ff}};
         rem_ff  <= (rem_sh >= {1'b0, den_ff}) ? 14'(rem_sh - {1'b0, den_ff}) : rem_sh[13:0];
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.finish && ndiv_ff) cap_ff <= cap_ff + quo_ff[13:0];
   end

   assign status.search_done = sdone_ff && !cmd.search_init;
   assign status.need_div    = ndiv_ff;
   assign status.div_done    = (dcnt_ff == 5'd28);
   assign rsp_voltage_mv         = filt_ff;
   assign rsp_capacity_centi_pct = cap_ff;
   assign rsp_empty_flag         = empty_ff;

   a_filt_range: assert property (@(posedge clock) disable iff (reset)
      cmd.blend |=> primed_ff) else $error("primed not set");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |=> first_ff <= last_ff) else $error("search bracket crossed");
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> den_ff != '0) else $error("divide by zero");
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for battery_voltage_fuel_gauge_unit: a scoreboard class
// predicts filtered voltage, capacity and empty flag for each accepted sample.
// Depends on bvfg_pkg and the RTL top level.
module tb_top;
   import bvfg_pkg::*;

   typedef struct {
      logic [13:0] mv;
      logic [13:0] cap;
      logic        empty;
   } gauge_reading_type;

   // Predicts gauge readings and holds those not yet returned
   class gauge_scoreboard_type;
      logic [23:0] scale;
      logic [31:0] rate;
      logic [13:0] set_mv;
      logic [13:0] clear_mv;
      logic [13:0] filt_mv;
      logic        empty_st;
      logic        primed;
      int          errors;
      gauge_reading_type pending[$];
      int curve_mv[43] = '{
         2805, 2900, 2984, 3075, 3150, 3192, 3241, 3274, 3301, 3327, 3367, 3406, 3430, 3453,
         3478, 3495, 3511, 3530, 3541, 3558, 3571, 3583, 3599, 3616, 3630, 3653, 3674, 3697,
         3725, 3753, 3774, 3799, 3823, 3860, 3888, 3909, 3939, 3967, 4016, 4053, 4081, 4107,
         4156};
      int curve_cap[43] = '{
         0, 10, 64, 140, 229, 297, 434, 659, 974, 1206, 1466, 1733, 1938, 2184,
         2478, 2690, 2916, 3224, 3429, 3709, 3983, 4188, 4434, 4728, 4960, 5234, 5487, 5719,
         6000, 6232, 6472, 6725, 6998, 7422, 7737, 7969, 8249, 8502, 8879, 9248, 9528, 9767,
         10000};

      function new();
         scale    = 24'd422814;
         rate     = 32'd69503;
         set_mv   = 14'd2800;
         clear_mv = 14'd3000;
         filt_mv  = '0;
         empty_st = 1'b0;
         primed   = 1'b0;
         errors   = 0;
      endfunction

      // Mirror a register write; indexes beyond the list are dropped
      function void write_reg(logic [CSR_INDEX_W:0] idx, logic [31:0] data);
         if (idx == {1'b0, REG_VOLT_SCALE}) scale = data[23:0];
         else if (idx == {1'b0, REG_RATE_PER_US}) rate = data;
         else if (idx == {1'b0, REG_EMPTY_SET}) set_mv = data[13:0];
         else if (idx == {1'b0, REG_EMPTY_CLEAR}) clear_mv = data[13:0];
      endfunction

      // Binary search of the curve, then linear interpolation
      function int capacity_at(int v);
         int lo, hi, mid, vf, vl, cf, cl;
         lo = 0;
         hi = 42;
         if (v < curve_mv[0]) return curve_cap[0];
         if (v > curve_mv[42]) return curve_cap[42];
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (v > curve_mv[mid]) lo = mid;
            else if (v < curve_mv[mid]) hi = mid;
            else return curve_cap[mid];
         end
         vf = curve_mv[lo];
         vl = curve_mv[hi];
         cf = curve_cap[lo];
         cl = curve_cap[hi];
         if (vl <= vf || cl < cf || v < vf) return cf;
         return cf + ((cl - cf) * (v - vf)) / (vl - vf);
      endfunction

      function void note_sample(logic [11:0] adc, logic [23:0] elapsed);
         logic [63:0] prod, wgt, acc;
         logic [13:0] smp;
         gauge_reading_type r;
         prod = (64'(adc) * 64'(scale) + 64'd32768) >> 16;
         smp  = (prod > 64'd16383) ? 14'h3FFF : prod[13:0];
         wgt  = (64'(rate) * 64'(elapsed)) >> 24;
         if (!primed || wgt >= 64'd65536) begin
            filt_mv = smp;
         end else begin
            acc = ((64'd65536 - wgt) * 64'(filt_mv) + wgt * 64'(smp) + 64'd32768) >> 16;
            filt_mv = (acc > 64'd16383) ? 14'h3FFF : acc[13:0];
         end
         primed = 1'b1;
         // Hysteresis: clear above the upper threshold, else set below the lower
         if (empty_st && filt_mv > clear_mv) empty_st = 1'b0;
         else if (filt_mv < set_mv) empty_st = 1'b1;
         r.mv    = filt_mv;
         r.cap   = 14'(capacity_at(int'(filt_mv)));
         r.empty = empty_st;
         pending.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_reading(logic [13:0] mv, logic [13:0] cap, logic empty);
         gauge_reading_type r;
         if (pending.size() == 0) begin
            report($sformatf("unexpected reading mv=%0d cap=%0d empty=%0d", mv, cap, empty));
            return;
         end
         r = pending.pop_front();
         if (mv !== r.mv) report($sformatf("voltage_mv %0d, want %0d", mv, r.mv));
         if (cap !== r.cap) report($sformatf("capacity %0d, want %0d (mv %0d)",
                                             cap, r.cap, r.mv));
         if (empty !== r.empty) report($sformatf("empty_flag %0d, want %0d (mv %0d)",
                                                 empty, r.empty, r.mv));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_adc_sample = '0;
   logic [23:0] req_elapsed_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [13:0] rsp_voltage_mv;
   logic [13:0] rsp_capacity_centi_pct;
   logic        rsp_empty_flag;
   logic        csr_write_enable = 1'b0;
   logic [CSR_INDEX_W:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   gauge_scoreboard_type sb = new();
   bit quiet_phase = 1'b0;
   int rsp_stall = 0;

   battery_voltage_fuel_gauge_unit u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_adc_sample         (req_adc_sample),
      .req_elapsed_us         (req_elapsed_us),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_voltage_mv         (rsp_voltage_mv),
      .rsp_capacity_centi_pct (rsp_capacity_centi_pct),
      .rsp_empty_flag         (rsp_empty_flag),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet_phase || r < 60) return 0;
      if (r < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Stall the result channel at random
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready = 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // Check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_reading(rsp_voltage_mv, rsp_capacity_centi_pct, rsp_empty_flag);
   end

   task automatic send_sample(logic [11:0] adc, logic [23:0] elapsed);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_adc_sample = adc;
      req_elapsed_us = elapsed;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(adc, elapsed);
   endtask

   // Wait for outstanding readings, then for the pipeline to settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic set_all(logic [31:0] scale, logic [31:0] rate, logic [31:0] lo,
                          logic [31:0] hi);
      write_reg({1'b0, REG_VOLT_SCALE}, scale);
      write_reg({1'b0, REG_RATE_PER_US}, rate);
      write_reg({1'b0, REG_EMPTY_SET}, lo);
      write_reg({1'b0, REG_EMPTY_CLEAR}, hi);
   endtask

   // Sample aimed at the discharge curve for the current scale, or anywhere
   function automatic logic [11:0] pick_adc();
      longint a;
      if ($urandom_range(99) < 40 || sb.scale == 0) return 12'($urandom);
      a = (longint'($urandom_range(4300, 2600)) * 65536) / longint'(sb.scale);
      return (a > 4095) ? 12'hFFF : 12'(a);
   endfunction

   function automatic logic [23:0] pick_elapsed();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 24'($urandom_range(64));
      if (r < 70) return 24'($urandom_range(2000));
      return 24'($urandom);
   endfunction

   function automatic logic [31:0] pick_threshold();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 32'd0;
      if (r == 1) return 32'd16383;
      if (r < 6) return $urandom_range(3600, 2600);
      return $urandom;
   endfunction

   initial begin
      logic [31:0] s, rt;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Defaults: first sample loads directly even with no elapsed time
      send_sample(12'd540, 24'd0);
      send_sample(12'd560, 24'd1000);
      send_sample(12'd0, 24'd0);
      send_sample(12'hFFF, 24'hFFFFFF);
      drain();

      // One mV per count, weight one but for the last sample: exact table points and edges
      set_all(32'd65536, 32'hFFFF_FFFF, 32'd2800, 32'd3000);
      send_sample(12'd2805, 24'd300);
      send_sample(12'd3301, 24'd300);
      send_sample(12'd3300, 24'd300);
      send_sample(12'd2804, 24'd300);
      send_sample(12'd2799, 24'd300);
      send_sample(12'd2900, 24'd300);
      send_sample(12'd3000, 24'd300);
      send_sample(12'd3001, 24'd300);
      send_sample(12'd4107, 24'd300);
      send_sample(12'd4095, 24'd0);
      drain();
      // Twice the scale reaches the top of the table and beyond
      set_all(32'd131072, 32'd0, 32'd0, 32'd16383);
      send_sample(12'd2078, 24'd0);
      send_sample(12'd2079, 24'hFFFFFF);
      send_sample(12'd0, 24'hFFFFFF);
      drain();
      // Saturated scale, ignored indexes beyond the list
      set_all(32'h00FF_FFFF, 32'd69503, 32'd16383, 32'd0);
      write_reg(3'd4, 32'h0);
      write_reg(3'd7, 32'h5A5A_5A5A);
      send_sample(12'hFFF, 24'd10);
      send_sample(12'd1, 24'd10);
      send_sample(12'd0, 24'd10);
      drain();

      // Random phases with varied settings
      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(3))
            0: s = 32'd422814;
            1: s = $urandom_range(140000, 50000);
            2: s = $urandom;
            default: s = 32'd65536;
         endcase
         case ($urandom_range(4))
            0: rt = 32'd0;
            1: rt = 32'hFFFF_FFFF;
            2: rt = 32'd69503;
            3: rt = $urandom_range(5000000);
            default: rt = $urandom;
         endcase
         set_all(s, rt, pick_threshold(), pick_threshold());
         quiet_phase = (ph == 2);
         for (int i = 0; i < 120; i++)
            send_sample(pick_adc(), pick_elapsed());
         drain();
      end

      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bvfg_pkg.sv
rtl/bvfg_ctrl.sv
rtl/bvfg_datapath.sv
rtl/battery_voltage_fuel_gauge_unit.sv
verif/tb_top.sv
